FILE: hw/rtl/dataproc_alu_with_barrel_shifter_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the data-processing ALU unit
// Concurrent assertion wrappers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef DATAPROC_ALU_WITH_BARREL_SHIFTER_UNIT_ASSERT_SVH
`define DATAPROC_ALU_WITH_BARREL_SHIFTER_UNIT_ASSERT_SVH

// Same-cycle implication
`define DPALU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dpalu: assertion failed");

// Next-cycle implication
`define DPALU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dpalu: assertion failed");

`endif

FILE: hw/rtl/dpalu_pkg.sv
// ----------------------------------------------------------------------------
// dpalu_pkg
// Types, opcodes and constants shared by the data-processing ALU unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpalu_pkg;

  localparam int unsigned NUM_REGS_DEFAULT = 15;
  localparam int unsigned DATA_W           = 32;
  localparam int unsigned IDX_W            = 4;
  localparam int unsigned CMD_W            = 4;
  localparam int unsigned KIND_W           = 3;
  localparam int unsigned SHAMT_W          = 5;
  localparam int unsigned ICARRY_W         = 2;

  // Immediate carry code: this bit set keeps the current C
  localparam int unsigned ICARRY_KEEP_BIT  = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_AND, CMD_EOR, CMD_SUB, CMD_RSB, CMD_ADD, CMD_ADC, CMD_SBC, CMD_RSC,
    CMD_TST, CMD_TEQ, CMD_CMP, CMD_CMN, CMD_ORR, CMD_MOV, CMD_BIC, CMD_MVN
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    SHK_LSL, SHK_LSR, SHK_ASR, SHK_ROR, SHK_RRX
  } shift_kind_e;

  typedef struct packed {
    logic                n;
    logic                z;
    logic                c;
    logic                v;
  } flags_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic                update_flags;
    logic [IDX_W-1:0]    dest_reg;
    logic [IDX_W-1:0]    first_reg;
    logic                operand_is_shifted;
    logic [DATA_W-1:0]   immediate_value;
    logic [ICARRY_W-1:0] immediate_carry;
    logic [IDX_W-1:0]    shift_reg;
    logic [KIND_W-1:0]   shift_kind;
    logic [SHAMT_W-1:0]  shift_amount;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]   result_value;
    logic                writes_register;
    logic [IDX_W-1:0]    written_index;
    logic                flag_n;
    logic                flag_z;
    logic                flag_c;
    logic                flag_v;
  } out_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]   op2;
    logic                carry;
  } shift_res_t;

  typedef struct packed {
    logic [DATA_W-1:0]   result;
    logic                is_test;
    flags_t              flags;
  } alu_res_t;

endpackage

FILE: hw/rtl/dpalu_in_if.sv
// ----------------------------------------------------------------------------
// dpalu_in_if
// Instruction channel: valid/ready handshake with one instruction per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dpalu_in_if;
  import dpalu_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/dpalu_out_if.sv
// ----------------------------------------------------------------------------
// dpalu_out_if
// Result channel: valid/ready handshake with one result per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dpalu_out_if;
  import dpalu_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/dpalu_ram.sv
// ----------------------------------------------------------------------------
// dpalu_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpalu_ram #(
  parameter  int unsigned WIDTH = 32,
  parameter  int unsigned DEPTH = 16,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read ports, old data on a same-edge write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: hw/rtl/dpalu_shifter.sv
// ----------------------------------------------------------------------------
// dpalu_shifter
// Barrel shifter: forms the second operand and the shifter carry-out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpalu_shifter (
  input  logic [dpalu_pkg::DATA_W-1:0]   x_i,
  input  logic                           shifted_i,
  input  logic [dpalu_pkg::DATA_W-1:0]   imm_i,
  input  logic [dpalu_pkg::ICARRY_W-1:0] icarry_i,
  input  logic [dpalu_pkg::KIND_W-1:0]   kind_i,
  input  logic [dpalu_pkg::SHAMT_W-1:0]  amount_i,
  input  logic                           c_i,
  output dpalu_pkg::shift_res_t          res_o
);
  import dpalu_pkg::*;

  logic [DATA_W:0]          lsl_w;
  logic [DATA_W:0]          lsr_w;
  logic signed [DATA_W:0]   asr_w;
  logic [2*DATA_W-1:0]      ror_w;
  logic                     amt_zero;

  // shifts with the last bit out kept next to the result
  assign lsl_w    = {1'b0, x_i} << amount_i;
  assign lsr_w    = {x_i, 1'b0} >> amount_i;
  assign asr_w    = $signed({x_i, 1'b0}) >>> amount_i;
  assign ror_w    = {x_i, x_i} >> amount_i;
  assign amt_zero = (amount_i == '0);

  // operand select
  always_comb begin
    res_o.op2   = imm_i;
    res_o.carry = icarry_i[ICARRY_KEEP_BIT] ? c_i : icarry_i[0];
    if (shifted_i) begin
      case (kind_i)
        SHK_LSL: begin
          if (amt_zero) begin
            res_o.op2   = x_i;
            res_o.carry = c_i;
          end else begin
            res_o.op2   = lsl_w[DATA_W-1:0];
            res_o.carry = lsl_w[DATA_W];
          end
        end
        SHK_LSR: begin
          // count zero means 32
          if (amt_zero) begin
            res_o.op2   = '0;
            res_o.carry = x_i[DATA_W-1];
          end else begin
            res_o.op2   = lsr_w[DATA_W:1];
            res_o.carry = lsr_w[0];
          end
        end
        SHK_ASR: begin
          if (amt_zero) begin
            res_o.op2   = {DATA_W{x_i[DATA_W-1]}};
            res_o.carry = x_i[DATA_W-1];
          end else begin
            res_o.op2   = asr_w[DATA_W:1];
            res_o.carry = asr_w[0];
          end
        end
        SHK_ROR: begin
          // count zero means RRX
          if (amt_zero) begin
            res_o.op2   = {c_i, x_i[DATA_W-1:1]};
            res_o.carry = x_i[0];
          end else begin
            res_o.op2   = ror_w[DATA_W-1:0];
            res_o.carry = ror_w[DATA_W-1];
          end
        end
        default: begin
          // RRX, and the unused kind codes
          res_o.op2   = {c_i, x_i[DATA_W-1:1]};
          res_o.carry = x_i[0];
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/dpalu_alu.sv
// ----------------------------------------------------------------------------
// dpalu_alu
// The 16 data-processing operations and the next condition flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpalu_alu (
  input  logic [dpalu_pkg::CMD_W-1:0]  cmd_i,
  input  logic                         update_flags_i,
  input  logic [dpalu_pkg::DATA_W-1:0] a_i,
  input  dpalu_pkg::shift_res_t        sh_i,
  input  dpalu_pkg::flags_t            flags_i,
  output dpalu_pkg::alu_res_t          res_o
);
  import dpalu_pkg::*;

  logic [DATA_W-1:0] add_a;
  logic [DATA_W-1:0] add_b;
  logic              add_cin;
  logic              logical;
  logic [DATA_W:0]   sum;
  logic              ovf;
  logic [DATA_W-1:0] op2;
  logic [DATA_W-1:0] alu_result;
  logic              is_test;
  flags_t            nxt_flags;

  assign op2 = sh_i.op2;

  // adder operand select
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    logical = 1'b0;
    case (cmd_i) inside
      CMD_SUB, CMD_CMP: begin
        add_a = a_i; add_b = ~op2; add_cin = 1'b1;
      end
      CMD_RSB: begin
        add_a = op2; add_b = ~a_i; add_cin = 1'b1;
      end
      CMD_ADD, CMD_CMN: begin
        add_a = a_i; add_b = op2;
      end
      CMD_ADC: begin
        add_a = a_i; add_b = op2; add_cin = flags_i.c;
      end
      CMD_SBC: begin
        add_a = a_i; add_b = ~op2; add_cin = flags_i.c;
      end
      CMD_RSC: begin
        add_a = op2; add_b = ~a_i; add_cin = flags_i.c;
      end
      default: logical = 1'b1;
    endcase
  end

  assign sum = {1'b0, add_a} + {1'b0, add_b} + {{DATA_W{1'b0}}, add_cin};
  assign ovf = (add_a[DATA_W-1] ^ sum[DATA_W-1]) & (add_b[DATA_W-1] ^ sum[DATA_W-1]);

  // result select
  always_comb begin
    case (cmd_i) inside
      CMD_AND, CMD_TST: alu_result = a_i & op2;
      CMD_EOR, CMD_TEQ: alu_result = a_i ^ op2;
      CMD_ORR:          alu_result = a_i | op2;
      CMD_MOV:          alu_result = op2;
      CMD_BIC:          alu_result = a_i & ~op2;
      CMD_MVN:          alu_result = ~op2;
      default:          alu_result = sum[DATA_W-1:0];
    endcase
  end

  assign is_test = (cmd_i == CMD_TST) || (cmd_i == CMD_TEQ) ||
                   (cmd_i == CMD_CMP) || (cmd_i == CMD_CMN);

  // next flags; logic ops take C from the shifter and keep V
  always_comb begin
    nxt_flags = flags_i;
    if (update_flags_i) begin
      nxt_flags.n = alu_result[DATA_W-1];
      nxt_flags.z = (alu_result == '0);
      nxt_flags.c = logical ? sh_i.carry : sum[DATA_W];
      nxt_flags.v = logical ? flags_i.v : ovf;
    end
  end

  assign res_o = '{result: alu_result, is_test: is_test, flags: nxt_flags};

endmodule

FILE: hw/rtl/dataproc_alu_with_barrel_shifter_unit.sv
// ----------------------------------------------------------------------------
// dataproc_alu_with_barrel_shifter_unit
// Throughput: one instruction per cycle, back to back, while the output is not stalled.
// Pipeline: the input beat is registered into the execute stage, which works on the
//   registered read of the register-file RAM; its result goes to the output register.
// Reset: flags and per-register valid bits clear at once, no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dataproc_alu_with_barrel_shifter_unit #(
  parameter int unsigned NUM_REGS = dpalu_pkg::NUM_REGS_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  dpalu_in_if.sink       in_i,
  dpalu_out_if.source    out_o
);
  import dpalu_pkg::*;

  localparam int unsigned       AW       = $clog2(NUM_REGS);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_REGS - 1);

  // control state
  logic                in_accept;
  logic                ex_move;
  logic                ex_valid_q, ex_valid_d;
  logic                out_valid_q, out_valid_d;
  flags_t              flags_q;
  logic [NUM_REGS-1:0] rf_vld_q;
  logic                lw_valid_q;

  // payload state
  in_item_t            ex_item_q;
  logic                rn_ok_q;
  logic                rm_ok_q;
  logic [IDX_W-1:0]    lw_idx_q;
  logic [DATA_W-1:0]   lw_data_q;
  out_item_t           out_item_q;

  // datapath
  logic [DATA_W-1:0]   rdata_a;
  logic [DATA_W-1:0]   rdata_b;
  logic [DATA_W-1:0]   rn_val;
  logic [DATA_W-1:0]   rm_val;
  logic                rf_we;
  shift_res_t          sh_res;
  alu_res_t            alu_res;

  // handshake
  assign in_accept   = in_i.valid && in_i.ready;
  assign ex_move     = ex_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !ex_valid_q || ex_move;
  assign ex_valid_d  = in_accept || (ex_valid_q && !ex_move);
  assign out_valid_d = ex_move || (out_valid_q && !out_o.ready);

  // register file, read on the input beat
  dpalu_ram #(
    .WIDTH (DATA_W),
    .DEPTH (NUM_REGS)
  ) u_rf (
    .clk_i     (clk_i),
    .we_i      (rf_we),
    .waddr_i   (ex_item_q.dest_reg[AW-1:0]),
    .wdata_i   (alu_res.result),
    .re_i      (in_accept),
    .raddr_a_i (in_i.data.first_reg[AW-1:0]),
    .raddr_b_i (in_i.data.shift_reg[AW-1:0]),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // operand fetch: forward the last write, zero for unwritten or absent regs
  assign rn_val = (lw_valid_q && (ex_item_q.first_reg == lw_idx_q)) ? lw_data_q :
                  rn_ok_q ? rdata_a : '0;
  assign rm_val = (lw_valid_q && (ex_item_q.shift_reg == lw_idx_q)) ? lw_data_q :
                  rm_ok_q ? rdata_b : '0;

  dpalu_shifter u_shifter (
    .x_i       (rm_val),
    .shifted_i (ex_item_q.operand_is_shifted),
    .imm_i     (ex_item_q.immediate_value),
    .icarry_i  (ex_item_q.immediate_carry),
    .kind_i    (ex_item_q.shift_kind),
    .amount_i  (ex_item_q.shift_amount),
    .c_i       (flags_q.c),
    .res_o     (sh_res)
  );

  dpalu_alu u_alu (
    .cmd_i          (ex_item_q.cmd),
    .update_flags_i (ex_item_q.update_flags),
    .a_i            (rn_val),
    .sh_i           (sh_res),
    .flags_i        (flags_q),
    .res_o          (alu_res)
  );

  // write back only for in-range destinations of non-test ops
  assign rf_we = ex_move && !alu_res.is_test && (ex_item_q.dest_reg <= LAST_IDX);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
      rf_vld_q    <= '0;
      lw_valid_q  <= 1'b0;
    end else begin
      ex_valid_q  <= ex_valid_d;
      out_valid_q <= out_valid_d;
      if (ex_move) begin
        flags_q <= alu_res.flags;
      end
      if (rf_we) begin
        rf_vld_q[ex_item_q.dest_reg[AW-1:0]] <= 1'b1;
        lw_valid_q                           <= 1'b1;
      end
    end
  end

  // execute stage payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      ex_item_q <= in_i.data;
      rn_ok_q   <= (in_i.data.first_reg <= LAST_IDX) &&
                   rf_vld_q[in_i.data.first_reg[AW-1:0]];
      rm_ok_q   <= (in_i.data.shift_reg <= LAST_IDX) &&
                   rf_vld_q[in_i.data.shift_reg[AW-1:0]];
    end
  end

  // last write, kept for forwarding
  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      lw_idx_q  <= ex_item_q.dest_reg;
      lw_data_q <= alu_res.result;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (ex_move) begin
      out_item_q.result_value    <= alu_res.result;
      out_item_q.writes_register <= !alu_res.is_test && (ex_item_q.dest_reg <= LAST_IDX);
      out_item_q.written_index   <= ex_item_q.dest_reg;
      out_item_q.flag_n          <= alu_res.flags.n;
      out_item_q.flag_z          <= alu_res.flags.z;
      out_item_q.flag_c          <= alu_res.flags.c;
      out_item_q.flag_v          <= alu_res.flags.v;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

endmodule

FILE: hw/rtl/dpalu_checker.sv
// ----------------------------------------------------------------------------
// dpalu_checker
// Port-level checks on the data-processing ALU unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dataproc_alu_with_barrel_shifter_unit_assert.svh"

module dpalu_checker #(
  parameter int unsigned NUM_REGS = dpalu_pkg::NUM_REGS_DEFAULT
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input dpalu_pkg::out_item_t out_data_i
);
  import dpalu_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_REGS - 1);

  // a stalled result beat stays put
  `DPALU_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))

  // a result beat only leaves when taken
  `DPALU_ASSERT_IMP(a_out_no_drop, clk_i, rst_ni, $fell(out_valid_i), $past(out_ready_i))

  // input back-pressure only comes from a blocked output
  `DPALU_ASSERT_IMP(a_ready_cause, clk_i, rst_ni, !in_ready_i, out_valid_i && !out_ready_i)

  // a reported write always targets an existing register
  `DPALU_ASSERT_IMP(a_write_range, clk_i, rst_ni, out_valid_i && out_data_i.writes_register, out_data_i.written_index <= LAST_IDX)

endmodule

bind dataproc_alu_with_barrel_shifter_unit dpalu_checker #(
  .NUM_REGS (NUM_REGS)
) u_dpalu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
